// ----- design/tlqs_pkg.sv -----
// ----------------------------------------------------------------------------
// tlqs_pkg: shared types and codes of the two-level queue scheduler
// Opcodes, status codes, register indexes, sequencer states, ALU operations.
// ----------------------------------------------------------------------------
package tlqs_pkg;

	// fixed field widths
	localparam int unsigned OpW     = 2;
	localparam int unsigned FieldW  = 8;
	localparam int unsigned StatusW = 3;
	localparam int unsigned PromW   = 5;
	localparam int unsigned CfgAddrW = 1;

	// opcodes
	localparam logic [OpW-1:0] OP_ADD      = 2'd0;
	localparam logic [OpW-1:0] OP_DISPATCH = 2'd1;
	localparam logic [OpW-1:0] OP_REPORT   = 2'd2;

	// result status codes
	localparam logic [StatusW-1:0] ST_ADDED  = 3'd0;
	localparam logic [StatusW-1:0] ST_GRANT  = 3'd1;
	localparam logic [StatusW-1:0] ST_IDLE   = 3'd2;
	localparam logic [StatusW-1:0] ST_FULL   = 3'd3;
	localparam logic [StatusW-1:0] ST_REPORT = 3'd4;

	// configuration register indexes and reset values
	localparam logic [CfgAddrW-1:0] REG_QUANTUM = 1'd0;
	localparam logic [CfgAddrW-1:0] REG_WAIT    = 1'd1;
	localparam logic [FieldW-1:0]   QUANTUM_RST = 8'd5;
	localparam logic [FieldW-1:0]   WAIT_RST    = 8'd50;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_P_RD,
		S_P_WAIT,
		S_P_UNTIL,
		S_G_RD,
		S_G_SEL,
		S_R_APPLY
	} state_t;

	// shared adder operations
	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

endpackage

// ----- design/two_level_queue_scheduler_with_aging_core.sv -----
// ----------------------------------------------------------------------------
// two_level_queue_scheduler_with_aging_core: round-robin scheduler with aging
// Foreground round-robin queue with quanta, background queue with arrival
// stamps, promotion of aged background jobs on dispatch.
// ----------------------------------------------------------------------------
// One item is in flight at a time. An add finishes in the execute state, a
// report advances the clock and then applies the used steps, and a dispatch
// with background jobs ages their head through the wait and until states,
// with a read state after each promotion, before it reads and selects a
// grant. These steps are set by the single shared adder, which serves
// every clock, wait and quantum computation in turn, and by the registered
// read of the queue memories, which needs a read state after each change
// of the background head. A result waits in the output register; a finished
// item holds in its last step while that register is still full.
// ----------------------------------------------------------------------------
module two_level_queue_scheduler_with_aging_core #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned ID_BITS     = 8,
	parameter int unsigned CLOCK_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // job_id[7:0], is_background[8], steps_used[16:9],
	                               // job_finished[17], zero[23:18]
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // grant_id[7:0], grant_steps[15:8],
	                               // grant_background[16], promoted_count[21:17], zero[23:22]
	output logic [2:0]  m_tuser,   // status[2:0]
	// configuration writes
	input  logic        cfg_we,
	input  logic [0:0]  cfg_addr,
	input  logic [7:0]  cfg_wdata
);

	localparam int unsigned AW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned IdW = (ID_BITS < 8) ? ID_BITS : 8;
	localparam int unsigned FgW = IdW + 8;
	localparam int unsigned BgW = IdW + CLOCK_BITS;
	localparam logic [CW-1:0] FullCount = CW'(QUEUE_DEPTH);

	// circular slot: (head + off) mod depth, sum stays below twice the depth
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
	                                       input logic [CW-1:0] off);
		logic [CW:0] s;
		s = (CW+1)'(head) + (CW+1)'(off);
		if (s >= (CW+1)'(QUEUE_DEPTH)) begin
			s = s - (CW+1)'(QUEUE_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	tlqs_pkg::state_t state_q, state_d;

	// latched input item
	logic [tlqs_pkg::OpW-1:0] op_q;
	logic [IdW-1:0]           id_q;
	logic                     bgsel_q;
	logic [7:0]               used_q;
	logic                     fin_q;

	// configuration
	logic [7:0] quantum_q, wait_q;

	// scheduler state
	logic [AW-1:0]         fg_head_q, bg_head_q;
	logic [CW-1:0]         fg_count_q, bg_count_q;
	logic [CLOCK_BITS-1:0] clock_q;
	logic                  from_bg_q;

	// dispatch scratch
	logic [CLOCK_BITS-1:0] waited_q;
	logic [7:0]            until_q;
	logic [4:0]            promoted_q;

	// result register
	logic       m_tvalid_q;
	logic [2:0] out_status_q;
	logic [7:0] out_id_q, out_steps_q;
	logic       out_bgf_q;
	logic [4:0] out_prom_q;

	// memories
	logic           fg_we, bg_we;
	logic [AW-1:0]  fg_waddr, bg_waddr;
	logic [FgW-1:0] fg_wdata, fg_rdata_q;
	logic [BgW-1:0] bg_wdata, bg_rdata_q;

	// shared adder
	tlqs_pkg::alu_op_t     alu_op;
	logic [CLOCK_BITS-1:0] alu_a, alu_b, alu_y;
	logic                  alu_borrow;

	logic [IdW-1:0] fg_rd_id, bg_rd_id;
	logic [7:0]     fg_rd_rem;
	logic [CLOCK_BITS-1:0] bg_rd_arr;
	logic out_free, fg_full, bg_any, fg_any, promote_cond, do_promote, finish;

	assign fg_rd_id  = fg_rdata_q[FgW-1:8];
	assign fg_rd_rem = fg_rdata_q[7:0];
	assign bg_rd_id  = bg_rdata_q[BgW-1:CLOCK_BITS];
	assign bg_rd_arr = bg_rdata_q[CLOCK_BITS-1:0];

	assign out_free = !m_tvalid_q || m_tready;
	assign fg_full  = (fg_count_q == FullCount);
	assign fg_any   = (fg_count_q != '0);
	assign bg_any   = (bg_count_q != '0);
	// wait - waited <= 0 means the head has aged out
	assign promote_cond = alu_borrow || (alu_y == '0);
	assign do_promote   = promote_cond && !fg_full;

	assign s_tready = (state_q == tlqs_pkg::S_IDLE);

	tlqs_mem #(.DEPTH(QUEUE_DEPTH), .WIDTH(FgW), .AW(AW)) u_fg_mem (
		.clk     (clk),
		.we      (fg_we),
		.waddr   (fg_waddr),
		.wdata   (fg_wdata),
		.raddr   (fg_head_q),
		.rdata_q (fg_rdata_q)
	);

	tlqs_mem #(.DEPTH(QUEUE_DEPTH), .WIDTH(BgW), .AW(AW)) u_bg_mem (
		.clk     (clk),
		.we      (bg_we),
		.waddr   (bg_waddr),
		.wdata   (bg_wdata),
		.raddr   (bg_head_q),
		.rdata_q (bg_rdata_q)
	);

	tlqs_alu #(.W(CLOCK_BITS)) u_alu (
		.op     (alu_op),
		.a      (alu_a),
		.b      (alu_b),
		.y      (alu_y),
		.borrow (alu_borrow)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tlqs_pkg::S_IDLE: begin
				if (s_tvalid) state_d = tlqs_pkg::S_EXEC;
			end
			tlqs_pkg::S_EXEC: begin
				case (op_q)
					tlqs_pkg::OP_DISPATCH: begin
						state_d = bg_any ? tlqs_pkg::S_P_WAIT : tlqs_pkg::S_G_RD;
					end
					tlqs_pkg::OP_REPORT: state_d = tlqs_pkg::S_R_APPLY;
					default: begin
						if (out_free) state_d = tlqs_pkg::S_IDLE;
					end
				endcase
			end
			tlqs_pkg::S_P_RD:   state_d = tlqs_pkg::S_P_WAIT;
			tlqs_pkg::S_P_WAIT: state_d = tlqs_pkg::S_P_UNTIL;
			tlqs_pkg::S_P_UNTIL: begin
				if (do_promote && (bg_count_q != CW'(1))) state_d = tlqs_pkg::S_P_RD;
				else state_d = tlqs_pkg::S_G_RD;
			end
			tlqs_pkg::S_G_RD: state_d = tlqs_pkg::S_G_SEL;
			tlqs_pkg::S_G_SEL, tlqs_pkg::S_R_APPLY: begin
				if (out_free) state_d = tlqs_pkg::S_IDLE;
			end
			default: state_d = tlqs_pkg::S_IDLE;
		endcase
	end

	// datapath control: adder operands and memory writes
	always_comb begin
		alu_op   = tlqs_pkg::ALU_SUB;
		alu_a    = clock_q;
		alu_b    = bg_rd_arr;
		fg_we    = 1'b0;
		fg_waddr = slot(fg_head_q, fg_count_q);
		fg_wdata = {id_q, quantum_q};
		bg_we    = 1'b0;
		bg_waddr = slot(bg_head_q, bg_count_q);
		bg_wdata = {id_q, clock_q};
		finish   = 1'b0;
		case (state_q)
			tlqs_pkg::S_EXEC: begin
				if (op_q == tlqs_pkg::OP_REPORT) begin
					alu_op = tlqs_pkg::ALU_ADD;
					alu_b  = CLOCK_BITS'(used_q);
				end else if (op_q != tlqs_pkg::OP_DISPATCH) begin
					finish = out_free;
					if (op_q == tlqs_pkg::OP_ADD && out_free) begin
						bg_we = bgsel_q && (bg_count_q != FullCount);
						fg_we = !bgsel_q && !fg_full;
					end
				end
			end
			tlqs_pkg::S_P_UNTIL: begin
				alu_a    = CLOCK_BITS'(wait_q);
				alu_b    = waited_q;
				fg_we    = do_promote;
				fg_wdata = {bg_rd_id, quantum_q};
			end
			tlqs_pkg::S_G_SEL: begin
				alu_a  = CLOCK_BITS'(fg_rd_rem);
				alu_b  = CLOCK_BITS'(until_q);
				finish = out_free;
			end
			tlqs_pkg::S_R_APPLY: begin
				alu_a  = CLOCK_BITS'(fg_rd_rem);
				alu_b  = CLOCK_BITS'(used_q);
				finish = out_free;
				if (out_free && !from_bg_q && fg_any && !fin_q) begin
					fg_we = 1'b1;
					if (!alu_borrow && (alu_y != '0)) begin
						// quantum left: shorten in place
						fg_waddr = fg_head_q;
						fg_wdata = {fg_rd_id, alu_y[7:0]};
					end else begin
						// quantum spent: rotate to tail with a fresh one
						fg_wdata = {fg_rd_id, quantum_q};
					end
				end
			end
			default: ;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= tlqs_pkg::QUANTUM_RST;
			wait_q    <= tlqs_pkg::WAIT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				tlqs_pkg::REG_QUANTUM: quantum_q <= cfg_wdata;
				tlqs_pkg::REG_WAIT:    wait_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q    <= s_tuser;
			id_q    <= s_tdata[IdW-1:0];
			bgsel_q <= s_tdata[8];
			used_q  <= s_tdata[16:9];
			fin_q   <= s_tdata[17];
		end
	end

	// sequencer and scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tlqs_pkg::S_IDLE;
			fg_head_q  <= '0;
			fg_count_q <= '0;
			bg_head_q  <= '0;
			bg_count_q <= '0;
			clock_q    <= '0;
			from_bg_q  <= 1'b0;
			promoted_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				tlqs_pkg::S_EXEC: begin
					promoted_q <= '0;
					if (op_q == tlqs_pkg::OP_REPORT) begin
						clock_q <= alu_y;
					end else if (op_q == tlqs_pkg::OP_ADD && out_free) begin
						if (bgsel_q && (bg_count_q != FullCount)) bg_count_q <= bg_count_q + 1'b1;
						if (!bgsel_q && !fg_full) fg_count_q <= fg_count_q + 1'b1;
					end
				end
				tlqs_pkg::S_P_UNTIL: begin
					if (do_promote) begin
						fg_count_q <= fg_count_q + 1'b1;
						bg_count_q <= bg_count_q - 1'b1;
						bg_head_q  <= slot(bg_head_q, CW'(1));
						promoted_q <= promoted_q + 1'b1;
					end
				end
				tlqs_pkg::S_G_SEL: begin
					if (out_free) begin
						if (fg_any) from_bg_q <= 1'b0;
						else if (bg_any) from_bg_q <= 1'b1;
					end
				end
				tlqs_pkg::S_R_APPLY: begin
					if (out_free) begin
						if (!from_bg_q) begin
							if (fg_any) begin
								if (fin_q) begin
									fg_head_q  <= slot(fg_head_q, CW'(1));
									fg_count_q <= fg_count_q - 1'b1;
								end else if (alu_borrow || (alu_y == '0)) begin
									fg_head_q <= slot(fg_head_q, CW'(1));
								end
							end
						end else if (bg_any && fin_q) begin
							bg_head_q  <= slot(bg_head_q, CW'(1));
							bg_count_q <= bg_count_q - 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// wait-time scratch
	always_ff @(posedge clk) begin
		if (state_q == tlqs_pkg::S_P_WAIT) begin
			waited_q <= alu_y;
		end
		if (state_q == tlqs_pkg::S_P_UNTIL) begin
			until_q <= promote_cond ? 8'd0 : alu_y[7:0];
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (finish) begin
			out_id_q    <= '0;
			out_steps_q <= '0;
			out_bgf_q   <= 1'b0;
			out_prom_q  <= '0;
			case (state_q)
				tlqs_pkg::S_EXEC: begin
					if (op_q == tlqs_pkg::OP_ADD) begin
						if (bgsel_q) begin
							out_status_q <= (bg_count_q == FullCount) ?
								tlqs_pkg::ST_FULL : tlqs_pkg::ST_ADDED;
						end else begin
							out_status_q <= fg_full ? tlqs_pkg::ST_FULL : tlqs_pkg::ST_ADDED;
						end
					end else begin
						out_status_q <= tlqs_pkg::ST_IDLE;
					end
				end
				tlqs_pkg::S_G_SEL: begin
					out_prom_q <= promoted_q;
					if (fg_any) begin
						out_status_q <= tlqs_pkg::ST_GRANT;
						out_id_q     <= 8'(fg_rd_id);
						// min(remaining, until) when a background job waits
						out_steps_q  <= (bg_any && !alu_borrow) ? until_q : fg_rd_rem;
					end else if (bg_any) begin
						out_status_q <= tlqs_pkg::ST_GRANT;
						out_id_q     <= 8'(bg_rd_id);
						out_steps_q  <= until_q;
						out_bgf_q    <= 1'b1;
					end else begin
						out_status_q <= tlqs_pkg::ST_IDLE;
					end
				end
				default: out_status_q <= tlqs_pkg::ST_REPORT;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {2'b00, out_prom_q, out_bgf_q, out_steps_q, out_id_q};

endmodule

// ----- design/tlqs_alu.sv -----
// ----------------------------------------------------------------------------
// tlqs_alu: shared add/subtract unit
// One clock-wide adder used for clock advance, wait time, time until
// promotion and quantum compares. Carry out doubles as the borrow flag.
// ----------------------------------------------------------------------------
module tlqs_alu #(
	parameter int unsigned W = 32
) (
	input  tlqs_pkg::alu_op_t op,
	input  logic [W-1:0]      a,
	input  logic [W-1:0]      b,
	output logic [W-1:0]      y,
	output logic              borrow
);

	logic [W:0] sum;

	// single adder, operand b inverted for subtract
	always_comb begin
		if (op == tlqs_pkg::ALU_SUB) begin
			sum = {1'b0, a} - {1'b0, b};
		end else begin
			sum = {1'b0, a} + {1'b0, b};
		end
	end

	assign y      = sum[W-1:0];
	assign borrow = sum[W];

endmodule

// ----- design/tlqs_mem.sv -----
// ----------------------------------------------------------------------------
// tlqs_mem: queue storage
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tlqs_mem #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned WIDTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

endmodule

// ----- design/tlqs_checker.sv -----
// ----------------------------------------------------------------------------
// tlqs_checker: port-level checks of the scheduler
// Watches the stream ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
module tlqs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [2:0]  m_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// status stays within its codes
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser <= tlqs_pkg::ST_REPORT))
		else $error("status code out of range");

	// grant fields are zero unless a grant
	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != tlqs_pkg::ST_GRANT) |-> (m_tdata[16:0] == 17'd0))
		else $error("grant fields set on a non-grant result");

	// one item at a time: not ready right after a transfer
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while busy");

endmodule

bind two_level_queue_scheduler_with_aging_core tlqs_checker u_tlqs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
